// ----- hdl/assert_macros.svh -----
// Assertion helpers; the enclosing module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ffa_pkg.sv -----
package ffa_pkg;

  localparam int HEAP_UNITS   = 65536;
  localparam int HEADER_BYTES = 16;
  localparam int HDR_SHIFT    = $clog2(HEADER_BYTES);
  localparam int ADDR_W       = $clog2(HEAP_UNITS);
  localparam int SIZE_W       = 17;
  localparam int BRK_W        = ADDR_W + 1;
  localparam int BYTES_W      = 21;
  localparam int GROW_W       = 16;
  localparam int GUARD_W      = 18;
  localparam int IGUARD_W     = 17;

  localparam logic [GUARD_W-1:0]  ALLOC_GUARD_MAX = GUARD_W'(3 * HEAP_UNITS + 8);
  localparam logic [IGUARD_W-1:0] INS_GUARD_MAX   = IGUARD_W'(HEAP_UNITS + 1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic CFG_MAX_REQ  = 1'b0;
  localparam logic CFG_MIN_GROW = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_OOM     = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] link;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    hdr_t              wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [ADDR_W-1:0] addr;
  } result_t;

endpackage

// ----- hdl/ffa_hdr_ram.sv -----
module ffa_hdr_ram
  import ffa_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output hdr_t     rdata
);

  hdr_t mem [HEAP_UNITS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- hdl/ffa_seq.sv -----
module ffa_seq
  import ffa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               cmd,
  input  logic [BYTES_W-1:0] req_bytes,
  input  logic [ADDR_W-1:0]  blk_addr,
  input  logic [BYTES_W-1:0] max_req,
  input  logic [GROW_W-1:0]  min_grow,
  input  logic               res_ready,
  output logic               idle,
  output result_t            res,
  output mem_req_t           mreq,
  input  hdr_t               rd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FREE_CHK, A_START, A_LINK, A_EVAL, A_CARVE_RD, A_CARVE_WR,
    I_START, I_EVAL, I_RDN, I_WRB, I_WRP, S_RESP
  } state_t;

  state_t               state_r;
  logic [ADDR_W-1:0]    clr_cnt_r;
  logic [SIZE_W-1:0]    nunits_r;
  logic [ADDR_W-1:0]    bp_r, prev_r, p_r, n_r, ip_r, free_start_r;
  hdr_t                 prev_hdr_r, bhdr_r, newb_r;
  logic [SIZE_W-1:0]    ip_size_r;
  logic [GUARD_W-1:0]   guard_r;
  logic [IGUARD_W-1:0]  iguard_r;
  logic                 ins_grow_r;
  logic [BRK_W-1:0]     brk_r;
  status_t              status_r;
  logic [ADDR_W-1:0]    addr_r;

  logic [BYTES_W:0]     bytes_rnd;
  logic [BYTES_W-HDR_SHIFT+1:0] nu_calc;
  logic [ADDR_W-1:0]    free_bp;
  logic                 ins_found;
  logic [SIZE_W-1:0]    carve_size;
  logic [SIZE_W-1:0]    grow_nu;
  logic                 merge_n, merge_p;
  hdr_t                 newb;

  assign bytes_rnd = (BYTES_W+1)'(req_bytes) + (BYTES_W+1)'(HEADER_BYTES - 1);
  assign nu_calc   = (BYTES_W-HDR_SHIFT+2)'(bytes_rnd >> HDR_SHIFT) + 1'b1;
  assign free_bp   = blk_addr - 1'b1;
  assign ins_found = ((bp_r > ip_r) && (bp_r < rd.link)) ||
                     ((ip_r >= rd.link) && ((bp_r > ip_r) || (bp_r < rd.link)));
  assign carve_size = rd.size - nunits_r;
  assign grow_nu    = (nunits_r < SIZE_W'(min_grow)) ? SIZE_W'(min_grow) : nunits_r;
  assign merge_n = ((BRK_W+1)'(bp_r) + (BRK_W+1)'(bhdr_r.size)) == (BRK_W+1)'(n_r);
  assign merge_p = ((BRK_W+1)'(ip_r) + (BRK_W+1)'(ip_size_r)) == (BRK_W+1)'(bp_r);

  always_comb begin
    newb.link = merge_n ? rd.link : n_r;
    newb.size = merge_n ? bhdr_r.size + rd.size : bhdr_r.size;
  end

  assign idle       = (state_r == S_IDLE);
  assign res.valid  = (state_r == S_RESP);
  assign res.status = status_r;
  assign res.addr   = addr_r;

  // Memory port: read and write addresses are driven from the current state.
  always_comb begin
    mreq = '0;
    case (state_r)
      S_CLR: begin
        mreq.we    = 1'b1;
        mreq.waddr = clr_cnt_r;
      end
      S_IDLE:  mreq.raddr = free_bp;
      A_START: mreq.raddr = free_start_r;
      I_START: mreq.raddr = free_start_r;
      A_LINK:  mreq.raddr = rd.link;
      A_EVAL: begin
        mreq.raddr = rd.link;
        if (guard_r <= ALLOC_GUARD_MAX) begin
          if (rd.size == nunits_r) begin
            mreq.we    = 1'b1;
            mreq.waddr = prev_r;
            mreq.wdata = '{link: rd.link, size: prev_hdr_r.size};
          end else if (rd.size > nunits_r) begin
            mreq.we    = 1'b1;
            mreq.waddr = p_r;
            mreq.wdata = '{link: rd.link, size: carve_size};
          end else if (p_r == free_start_r &&
                       BRK_W'(grow_nu) <= BRK_W'(HEAP_UNITS) - brk_r) begin
            mreq.we    = 1'b1;
            mreq.waddr = brk_r[ADDR_W-1:0];
            mreq.wdata = '{link: '0, size: grow_nu};
          end
        end
      end
      A_CARVE_RD: mreq.raddr = p_r;
      A_CARVE_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = p_r;
        mreq.wdata = '{link: rd.link, size: nunits_r};
      end
      I_EVAL:  mreq.raddr = ins_found ? bp_r : rd.link;
      I_RDN:   mreq.raddr = n_r;
      I_WRB: begin
        mreq.we    = 1'b1;
        mreq.waddr = bp_r;
        mreq.wdata = newb;
      end
      I_WRP: begin
        mreq.we    = 1'b1;
        mreq.waddr = ip_r;
        if (merge_p) begin
          mreq.wdata.link = newb_r.link;
          mreq.wdata.size = ip_size_r + newb_r.size;
        end else begin
          mreq.wdata.link = bp_r;
          mreq.wdata.size = ip_size_r;
        end
      end
      default: mreq = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= '0;
      free_start_r <= '0;
      brk_r        <= BRK_W'(1);
      status_r     <= ST_OK;
      addr_r       <= '0;
      ins_grow_r   <= 1'b0;
      guard_r      <= '0;
      iguard_r     <= '0;
    end else begin
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (&clr_cnt_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            addr_r   <= '0;
            status_r <= ST_OK;
            guard_r  <= '0;
            if (cmd == CMD_ALLOC) begin
              if (req_bytes == '0 || req_bytes > max_req) begin
                status_r <= ST_REJECT;
                state_r  <= S_RESP;
              end else if (nu_calc > (BYTES_W-HDR_SHIFT+2)'(HEAP_UNITS)) begin
                status_r <= ST_OOM;
                state_r  <= S_RESP;
              end else begin
                nunits_r <= SIZE_W'(nu_calc);
                state_r  <= A_START;
              end
            end else if (blk_addr == '0) begin
              state_r <= S_RESP;
            end else if (free_bp == '0 || BRK_W'(free_bp) >= brk_r) begin
              status_r <= ST_BADFREE;
              state_r  <= S_RESP;
            end else begin
              bp_r    <= free_bp;
              state_r <= S_FREE_CHK;
            end
          end
        end
        S_FREE_CHK: begin
          if (rd.size == '0 || BYTES_W'(rd.size) > max_req ||
              BRK_W'(rd.size) > brk_r - BRK_W'(bp_r)) begin
            status_r <= ST_BADFREE;
            state_r  <= S_RESP;
          end else begin
            ins_grow_r <= 1'b0;
            state_r    <= I_START;
          end
        end
        A_START: state_r <= A_LINK;
        A_LINK: begin
          prev_r     <= free_start_r;
          prev_hdr_r <= rd;
          p_r        <= rd.link;
          state_r    <= A_EVAL;
        end
        A_EVAL: begin
          if (guard_r > ALLOC_GUARD_MAX) begin
            status_r <= ST_OOM;
            state_r  <= S_RESP;
          end else if (rd.size == nunits_r) begin
            free_start_r <= prev_r;
            addr_r       <= p_r + 1'b1;
            state_r      <= S_RESP;
          end else if (rd.size > nunits_r) begin
            free_start_r <= prev_r;
            p_r          <= p_r + carve_size[ADDR_W-1:0];
            state_r      <= A_CARVE_RD;
          end else if (p_r == free_start_r) begin
            if (BRK_W'(grow_nu) > BRK_W'(HEAP_UNITS) - brk_r) begin
              status_r <= ST_OOM;
              state_r  <= S_RESP;
            end else begin
              bp_r       <= brk_r[ADDR_W-1:0];
              brk_r      <= brk_r + BRK_W'(grow_nu);
              ins_grow_r <= 1'b1;
              guard_r    <= guard_r + 1'b1;
              state_r    <= I_START;
            end
          end else begin
            // advance one link
            prev_r     <= p_r;
            prev_hdr_r <= rd;
            p_r        <= rd.link;
            guard_r    <= guard_r + 1'b1;
          end
        end
        A_CARVE_RD: state_r <= A_CARVE_WR;
        A_CARVE_WR: begin
          addr_r  <= p_r + 1'b1;
          state_r <= S_RESP;
        end
        I_START: begin
          ip_r     <= free_start_r;
          iguard_r <= '0;
          state_r  <= I_EVAL;
        end
        I_EVAL: begin
          if (iguard_r > INS_GUARD_MAX) begin
            status_r <= ins_grow_r ? ST_OOM : ST_BADFREE;
            state_r  <= S_RESP;
          end else if (ins_found) begin
            n_r       <= rd.link;
            ip_size_r <= rd.size;
            state_r   <= I_RDN;
          end else begin
            ip_r     <= rd.link;
            iguard_r <= iguard_r + 1'b1;
          end
        end
        I_RDN: begin
          bhdr_r  <= rd;
          state_r <= I_WRB;
        end
        I_WRB: begin
          newb_r  <= newb;
          state_r <= I_WRP;
        end
        I_WRP: begin
          free_start_r <= ip_r;
          state_r      <= ins_grow_r ? A_START : S_RESP;
        end
        S_RESP: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/first_fit_free_list_allocator_core.sv -----
// First-fit heap allocator over a 65536-unit arena of 16-byte headers, all
// kept in one single-port-read header RAM. After reset the core sweeps the
// RAM to zero, entry by entry, before it takes its first transaction;
// configuration writes are taken at any time. One transaction is worked at
// a time. The free-list walk in the header RAM sets how long each takes: an
// allocate visits list links one after another (plus an insert pass when
// the arena grows); a free visits links while finding its address-ordered
// slot. Results sit in an output register, so the next transaction is
// accepted while a result waits.
module first_fit_free_list_allocator_core
  import ffa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // request_bytes[20:0], block_addr[36:21], zero pad
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // payload_addr[15:0]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [20:0] cfg_data
);

`include "assert_macros.svh"

  logic [BYTES_W-1:0] max_req_r;
  logic [GROW_W-1:0]  min_grow_r;
  logic               seq_idle;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic               res_ready;
  result_t            res;
  mem_req_t           mreq;
  hdr_t               rd;

  assign cfg_ready  = 1'b1;
  assign in_tready  = seq_idle;
  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_req_r  <= BYTES_W'(1048576);
      min_grow_r <= GROW_W'(1024);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MAX_REQ) begin
        max_req_r <= cfg_data;
      end else begin
        min_grow_r <= cfg_data[GROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r  <= 1'b1;
      out_status_r <= res.status;
      out_addr_r   <= res.addr;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  ffa_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && in_tready),
    .cmd       (in_tuser),
    .req_bytes (in_tdata[20:0]),
    .blk_addr  (in_tdata[36:21]),
    .max_req   (max_req_r),
    .min_grow  (min_grow_r),
    .res_ready (res_ready),
    .idle      (seq_idle),
    .res       (res),
    .mreq      (mreq),
    .rd        (rd)
  );

  ffa_hdr_ram u_ram (
    .clk   (clk),
    .req   (mreq),
    .rdata (rd)
  );

  `ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `ASSERT_IMPLIES(a_fail_no_addr, out_tvalid && out_tuser != ST_OK, out_tdata == '0,
                  "failed result carries an address")
  `ASSERT_IMPLIES(a_no_write_idle, in_tready, !mreq.we, "RAM written while idle")

endmodule
